FILE: rtl/envelope_mixer_ramp_assert.svh
// Assertion macros shared by the envelope mixer checkers.
// Needs a clock and an active-high reset named clock and reset in scope.
`ifndef ENVELOPE_MIXER_RAMP_ASSERT_SVH
`define ENVELOPE_MIXER_RAMP_ASSERT_SVH

// Checked at every edge, reset included.
`define EMR_ASSERT_NEXT(name, trig, expr) \
   name: assert property (@(posedge clock) (trig) |=> (expr)) \
      else $error("envelope mixer check failed");

// Checked only while out of reset.
`define EMR_ASSERT_RUN(name, trig, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("envelope mixer check failed");

`endif

FILE: rtl/emr_pkg.sv
// Types, register indexes and saturation helper for the envelope mixer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package emr_pkg;

   localparam int Q15_SHIFT = 15;
   localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAT_MIN = 16'sh8000;

   typedef enum logic [7:0] {
      REG_DRY_GAIN     = 8'd0,
      REG_WET_GAIN     = 8'd1,
      REG_START_LEFT   = 8'd2,
      REG_START_RIGHT  = 8'd3,
      REG_TARGET_LEFT  = 8'd4,
      REG_TARGET_RIGHT = 8'd5,
      REG_RATE_LEFT    = 8'd6,
      REG_RATE_RIGHT   = 8'd7
   } emr_reg_type;

   typedef struct packed {
      logic signed [15:0] dry_gain;
      logic signed [15:0] wet_gain;
      logic signed [15:0] start_left;
      logic signed [15:0] start_right;
      logic signed [15:0] target_left;
      logic signed [15:0] target_right;
      logic signed [15:0] rate_left;
      logic signed [15:0] rate_right;
   } emr_csr_type;

   // One classified sample as it travels from the front end to the back end.
   typedef struct packed {
      logic signed [15:0] sample;
      logic signed [15:0] dry_left;
      logic signed [15:0] dry_right;
      logic signed [15:0] wet_left;
      logic signed [15:0] wet_right;
      logic               aux;
      logic               last;
      logic signed [15:0] mix_vol_left;
      logic signed [15:0] mix_vol_right;
      logic signed [15:0] new_vol_left;
      logic signed [15:0] new_vol_right;
   } emr_item_type;

   typedef struct packed {
      logic signed [15:0] dry_left;
      logic signed [15:0] dry_right;
      logic signed [15:0] wet_left;
      logic signed [15:0] wet_right;
      logic signed [15:0] volume_left;
      logic signed [15:0] volume_right;
      logic               end_of_buffer;
   } emr_result_type;

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > 19'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < 19'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/envelope_mixer_ramp.sv
// Top level of the envelope mixer with per-sample volume ramps.
// Instantiates emr_csr, emr_front, emr_queue and emr_back; depends on emr_pkg.
`timescale 1ns / 1ps

// The front end takes one sample per cycle while the queue has room, loads
// the start volumes on restart and steps both ramps right away, so volume
// state never waits on the multipliers. The back end handles one sample at
// a time, in steps (dequeue, volume scaling multiply, gain multiply,
// saturating add), and waits in the add step while the previous result
// has not been taken. The result register holds one beat, the back end
// works on one more sample, and QUEUE_DEPTH samples can queue up behind
// them before full rises. Configuration beats are always accepted and
// must be written while the block is idle.
module envelope_mixer_ramp #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_sample,
   input  logic signed [15:0] req_dry_left_in,
   input  logic signed [15:0] req_dry_right_in,
   input  logic signed [15:0] req_wet_left_in,
   input  logic signed [15:0] req_wet_right_in,
   input  logic               req_restart,
   input  logic               req_aux,
   input  logic               req_last,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_dry_left_out,
   output logic signed [15:0] rsp_dry_right_out,
   output logic signed [15:0] rsp_wet_left_out,
   output logic signed [15:0] rsp_wet_right_out,
   output logic signed [15:0] rsp_volume_left,
   output logic signed [15:0] rsp_volume_right,
   output logic               rsp_end_of_buffer,
   input  logic               valid,
   output logic               ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import emr_pkg::*;

   emr_csr_type    regs;
   emr_item_type   fe_data;
   emr_item_type   q_data;
   emr_result_type rsp;
   logic           fe_push;
   logic           q_full;
   logic           q_empty;
   logic           q_pop;

   assign full = q_full;

   emr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .regs      (regs)
   );

   emr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_sample       (req_sample),
      .req_dry_left_in  (req_dry_left_in),
      .req_dry_right_in (req_dry_right_in),
      .req_wet_left_in  (req_wet_left_in),
      .req_wet_right_in (req_wet_right_in),
      .req_restart      (req_restart),
      .req_aux          (req_aux),
      .req_last         (req_last),
      .regs             (regs),
      .q_full           (q_full),
      .q_push           (fe_push),
      .q_data           (fe_data)
   );

   emr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fe_push),
      .wr_data (fe_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   emr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .regs    (regs),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

   assign rsp_dry_left_out  = rsp.dry_left;
   assign rsp_dry_right_out = rsp.dry_right;
   assign rsp_wet_left_out  = rsp.wet_left;
   assign rsp_wet_right_out = rsp.wet_right;
   assign rsp_volume_left   = rsp.volume_left;
   assign rsp_volume_right  = rsp.volume_right;
   assign rsp_end_of_buffer = rsp.end_of_buffer;

endmodule

FILE: rtl/emr_csr.sv
// Configuration register file of the envelope mixer.
// Depends on emr_pkg for the register indexes and the register struct.
`timescale 1ns / 1ps

module emr_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid,
   output logic                ready,
   input  logic [7:0]          csr_index,
   input  logic [15:0]         csr_data,
   output emr_pkg::emr_csr_type regs
);
   import emr_pkg::*;

   emr_csr_type regs_ff;
   emr_csr_type regs_in;

   assign ready = 1'b1;
   assign regs  = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (valid) begin
         unique case (csr_index)
            REG_DRY_GAIN:     regs_in.dry_gain     = csr_data;
            REG_WET_GAIN:     regs_in.wet_gain     = csr_data;
            REG_START_LEFT:   regs_in.start_left   = csr_data;
            REG_START_RIGHT:  regs_in.start_right  = csr_data;
            REG_TARGET_LEFT:  regs_in.target_left  = csr_data;
            REG_TARGET_RIGHT: regs_in.target_right = csr_data;
            REG_RATE_LEFT:    regs_in.rate_left    = csr_data;
            REG_RATE_RIGHT:   regs_in.rate_right   = csr_data;
            default:          regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

FILE: rtl/emr_front.sv
// Front end: accepts samples, applies restart and steps the volume ramps.
// Depends on emr_pkg; feeds classified items into emr_queue.
`timescale 1ns / 1ps

module emr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic signed [15:0]    req_sample,
   input  logic signed [15:0]    req_dry_left_in,
   input  logic signed [15:0]    req_dry_right_in,
   input  logic signed [15:0]    req_wet_left_in,
   input  logic signed [15:0]    req_wet_right_in,
   input  logic                  req_restart,
   input  logic                  req_aux,
   input  logic                  req_last,
   input  emr_pkg::emr_csr_type  regs,
   input  logic                  q_full,
   output logic                  q_push,
   output emr_pkg::emr_item_type q_data
);
   import emr_pkg::*;

   logic signed [15:0] vol_left_ff;
   logic signed [15:0] vol_right_ff;
   logic signed [15:0] mix_left;
   logic signed [15:0] mix_right;
   logic signed [15:0] next_left;
   logic signed [15:0] next_right;

   // A step stops at the target from either side and never overshoots it.
   function automatic logic signed [15:0] ramp(
      input logic signed [15:0] vol,
      input logic signed [15:0] rate,
      input logic signed [15:0] target
   );
      logic signed [16:0] v;
      logic signed [16:0] t;
      logic signed [15:0] r;
      v = 17'(vol) + 17'(rate);
      t = 17'(target);
      if (rate == 16'sd0) begin
         r = vol;
      end else begin
         if (!rate[15]) begin
            if (v > t) v = t;
         end else begin
            if (v < t) v = t;
         end
         r = sat16(19'(v));
      end
      return r;
   endfunction

   assign q_push     = push && !q_full;
   assign mix_left   = req_restart ? regs.start_left  : vol_left_ff;
   assign mix_right  = req_restart ? regs.start_right : vol_right_ff;
   assign next_left  = ramp(mix_left,  regs.rate_left,  regs.target_left);
   assign next_right = ramp(mix_right, regs.rate_right, regs.target_right);

   always_comb begin
      q_data.sample        = req_sample;
      q_data.dry_left      = req_dry_left_in;
      q_data.dry_right     = req_dry_right_in;
      q_data.wet_left      = req_wet_left_in;
      q_data.wet_right     = req_wet_right_in;
      q_data.aux           = req_aux;
      q_data.last          = req_last;
      q_data.mix_vol_left  = mix_left;
      q_data.mix_vol_right = mix_right;
      q_data.new_vol_left  = next_left;
      q_data.new_vol_right = next_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_left_ff  <= '0;
         vol_right_ff <= '0;
      end else if (q_push) begin
         vol_left_ff  <= next_left;
         vol_right_ff <= next_right;
      end
   end

endmodule

FILE: rtl/emr_queue.sv
// Small FIFO that decouples the front end from the mixing back end.
// Depends on emr_pkg for the item type.
`timescale 1ns / 1ps

module emr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  emr_pkg::emr_item_type wr_data,
   output logic                  full,
   input  logic                  rd_en,
   output emr_pkg::emr_item_type rd_data,
   output logic                  empty
);
   import emr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   emr_item_type       slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_wr;
   logic               do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/emr_back.sv
// Back end: volume scaling, gain multiply, saturating mix (wet side only with aux) and result register.
// Depends on emr_pkg; drains items from emr_queue.
`timescale 1ns / 1ps

module emr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  emr_pkg::emr_csr_type    regs,
   input  logic                    q_empty,
   input  emr_pkg::emr_item_type   q_data,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output emr_pkg::emr_result_type rsp
);
   import emr_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_GAIN, ST_SUM} state_type;

   state_type          state_ff,     state_in;
   emr_item_type       item_ff,      item_in;
   logic signed [16:0] scaled_l_ff,  scaled_l_in;
   logic signed [16:0] scaled_r_ff,  scaled_r_in;
   logic signed [17:0] dl_p_ff,      dl_p_in;
   logic signed [17:0] dr_p_ff,      dr_p_in;
   logic signed [17:0] wl_p_ff,      wl_p_in;
   logic signed [17:0] wr_p_ff,      wr_p_in;
   logic               rsp_valid_ff, rsp_valid_in;
   emr_result_type     rsp_ff,       rsp_in;

   logic signed [31:0] prod_l;
   logic signed [31:0] prod_r;
   logic signed [32:0] dl_full;
   logic signed [32:0] dr_full;
   logic signed [32:0] wl_full;
   logic signed [32:0] wr_full;
   logic signed [18:0] dl_sum;
   logic signed [18:0] dr_sum;
   logic signed [18:0] wl_sum;
   logic signed [18:0] wr_sum;
   logic               out_beat;

   assign empty    = !rsp_valid_ff;
   assign rsp      = rsp_ff;
   assign out_beat = pop && rsp_valid_ff;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   // Part-selects of the upper product bits keep floor rounding for negative products.
   assign prod_l  = 32'(item_ff.sample) * 32'(item_ff.mix_vol_left);
   assign prod_r  = 32'(item_ff.sample) * 32'(item_ff.mix_vol_right);
   assign dl_full = 33'(scaled_l_ff) * 33'(regs.dry_gain);
   assign dr_full = 33'(scaled_r_ff) * 33'(regs.dry_gain);
   assign wl_full = 33'(scaled_l_ff) * 33'(regs.wet_gain);
   assign wr_full = 33'(scaled_r_ff) * 33'(regs.wet_gain);
   assign dl_sum  = 19'(item_ff.dry_left)  + 19'(dl_p_ff);
   assign dr_sum  = 19'(item_ff.dry_right) + 19'(dr_p_ff);
   assign wl_sum  = 19'(item_ff.wet_left)  + 19'(wl_p_ff);
   assign wr_sum  = 19'(item_ff.wet_right) + 19'(wr_p_ff);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      scaled_l_in  = scaled_l_ff;
      scaled_r_in  = scaled_r_ff;
      dl_p_in      = dl_p_ff;
      dr_p_in      = dr_p_ff;
      wl_p_in      = wl_p_ff;
      wr_p_in      = wr_p_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !out_beat;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               item_in  = q_data;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            scaled_l_in = prod_l[31:Q15_SHIFT];
            scaled_r_in = prod_r[31:Q15_SHIFT];
            state_in    = ST_GAIN;
         end
         ST_GAIN: begin
            dl_p_in  = dl_full[32:Q15_SHIFT];
            dr_p_in  = dr_full[32:Q15_SHIFT];
            wl_p_in  = wl_full[32:Q15_SHIFT];
            wr_p_in  = wr_full[32:Q15_SHIFT];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Wait here while the previous result has not been taken.
            if (!rsp_valid_ff || out_beat) begin
               rsp_in.dry_left      = sat16(dl_sum);
               rsp_in.dry_right     = sat16(dr_sum);
               rsp_in.wet_left      = item_ff.aux ? sat16(wl_sum) : item_ff.wet_left;
               rsp_in.wet_right     = item_ff.aux ? sat16(wr_sum) : item_ff.wet_right;
               rsp_in.volume_left   = item_ff.new_vol_left;
               rsp_in.volume_right  = item_ff.new_vol_right;
               rsp_in.end_of_buffer = item_ff.last;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      scaled_l_ff <= scaled_l_in;
      scaled_r_ff <= scaled_r_in;
      dl_p_ff     <= dl_p_in;
      dr_p_ff     <= dr_p_in;
      wl_p_ff     <= wl_p_in;
      wr_p_ff     <= wr_p_in;
      rsp_ff      <= rsp_in;
   end

endmodule

FILE: rtl/emr_checker.sv
// Port-level checker for the envelope mixer, bound to the top level.
// Depends on envelope_mixer_ramp_assert.svh for the assertion macros.
`timescale 1ns / 1ps

module emr_checker (
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input logic               empty,
   input logic               pop,
   input logic signed [15:0] rsp_dry_left_out,
   input logic signed [15:0] rsp_dry_right_out,
   input logic signed [15:0] rsp_wet_left_out,
   input logic signed [15:0] rsp_wet_right_out,
   input logic signed [15:0] rsp_volume_left,
   input logic signed [15:0] rsp_volume_right,
   input logic               rsp_end_of_buffer
);
`include "envelope_mixer_ramp_assert.svh"

   // Reset drops every queued sample and the pending result.
   `EMR_ASSERT_NEXT(a_reset_clears, reset, empty && !full)

   // A result is registered only after its sample has passed the idle, scale,
   // gain and sum states, so the output is still empty when this check samples it.
   `EMR_ASSERT_NEXT(a_min_latency, reset ##2 1'b1, empty)

   // A result that is not taken stays put.
   `EMR_ASSERT_RUN(a_result_holds, !empty && !pop,
      !empty && $stable(rsp_dry_left_out) && $stable(rsp_dry_right_out) &&
      $stable(rsp_wet_left_out) && $stable(rsp_wet_right_out) &&
      $stable(rsp_volume_left) && $stable(rsp_volume_right) &&
      $stable(rsp_end_of_buffer))

endmodule

bind envelope_mixer_ramp emr_checker u_checker (.*);
